@@ src/hlcf_pkg.sv @@
// Shared types and constants of the Hough line corner finder.
`default_nettype none
package hlcf_pkg;

	// Field widths
	localparam int RHO_W     = 16;
	localparam int THETA_W   = 10;
	localparam int LINE_W    = RHO_W + THETA_W;
	localparam int COORD_W   = 15;
	localparam int REG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int TRIG_W    = 16;

	// Arithmetic widths
	localparam int MUL_W  = 20;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 32;
	localparam int FRAC_SHIFT = 11;
	localparam int NUM_W  = ACC_W + FRAC_SHIFT;
	localparam int DEN_W  = ACC_W;

	// Coordinate saturation magnitudes
	localparam int COORD_POS_MAX = 16383;
	localparam int COORD_NEG_MAX = 16384;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_DIST   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [REG_W-1:0] MERGE_DIST_RST   = 13'd10;
	localparam logic [REG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
	localparam logic [REG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

	// Datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_READ_I,
		OP_LATCH_I,
		OP_READ_J,
		OP_LATCH_J,
		OP_TRIG,
		OP_PROD,
		OP_DIVX_GO,
		OP_DIVX_TAKE,
		OP_DIVY_GO,
		OP_DIVY_TAKE,
		OP_SCAN_START,
		OP_SCAN_NEXT,
		OP_AVG,
		OP_APPEND,
		OP_NEXT_J,
		OP_NEXT_I,
		OP_EMIT_START,
		OP_EMIT
	} op_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_RD_I,
		ST_LAT_I,
		ST_RD_J,
		ST_LAT_J,
		ST_TRIG,
		ST_PROD,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_CHECK,
		ST_SCAN,
		ST_AVG,
		ST_APPEND,
		ST_NEXT_J,
		ST_NEXT_I,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] step;
		logic [1:0] sub;
	} cmd_t;

	typedef struct packed {
		logic cls_y;
		logic i_end;
		logic j_end;
		logic den_zero;
		logic div_busy;
		logic in_bounds;
		logic scan_end;
		logic hit;
		logic out_free;
		logic emit_last;
	} stat_t;

endpackage
`default_nettype wire

@@ src/hlcf_div.sv @@
// Iterative restoring divider with signed, saturated coordinate result.
`default_nettype none
module hlcf_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hlcf_pkg::NUM_W-1:0]    num,
	input  wire logic [hlcf_pkg::DEN_W-1:0]    den,
	input  wire logic                          neg,
	output logic                               busy,
	output logic signed [hlcf_pkg::COORD_W-1:0] quo
);
	import hlcf_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// One quotient bit per cycle
	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	// Apply sign and clamp to the coordinate range
	always_comb begin
		if (neg_q) begin
			if (num_q > NUM_W'(COORD_NEG_MAX)) begin
				quo = -COORD_W'(COORD_NEG_MAX);
			end else begin
				quo = -num_q[COORD_W-1:0];
			end
		end else begin
			if (num_q > NUM_W'(COORD_POS_MAX)) begin
				quo = COORD_W'(COORD_POS_MAX);
			end else begin
				quo = num_q[COORD_W-1:0];
			end
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

@@ src/hlcf_dp.sv @@
// Datapath: line memory, trig and product unit, divider, corner list, output register.
`default_nettype none
module hlcf_dp #(
	parameter int MAX_LINES   = 32,
	parameter int MAX_CORNERS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hlcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [hlcf_pkg::REG_W-1:0]        cfg_data,
	input  wire logic [hlcf_pkg::RHO_W-1:0]        in_rho,
	input  wire logic [hlcf_pkg::THETA_W-1:0]      in_theta,
	input  wire hlcf_pkg::cmd_t                    cmd,
	output hlcf_pkg::stat_t                        stat,
	input  wire logic                              m_tready,
	output logic                                   out_valid,
	output logic                                   out_found,
	output logic [hlcf_pkg::COORD_W-1:0]           out_x,
	output logic [hlcf_pkg::COORD_W-1:0]           out_y,
	output logic                                   out_ovf,
	output logic                                   out_last
);
	import hlcf_pkg::*;

	localparam int LIDX_W = $clog2(MAX_LINES);
	localparam int LCNT_W = $clog2(MAX_LINES + 1);
	localparam int CIDX_W = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
	localparam int CCNT_W = $clog2(MAX_CORNERS + 1);

	// Configuration
	logic [REG_W-1:0] merge_dist_q, width_q, height_q;

	// Line store and pair registers
	logic [LINE_W-1:0]  line_mem [MAX_LINES];
	logic [LINE_W-1:0]  line_rd_q;
	logic [LIDX_W-1:0]  rd_idx;
	logic [LCNT_W-1:0]  line_cnt_q, i_q, j_q;
	logic               line_full;
	logic [THETA_W-1:0] theta0_q, theta_i_q, theta_j_q;
	logic signed [RHO_W-1:0] rho_i_q, rho_j_q;
	logic               dropped_q;

	// Corner list
	logic [CCNT_W-1:0]  ccnt_q, cidx_q;
	logic [CIDX_W-1:0]  cidx_i;
	logic               corner_full;
	logic signed [COORD_W-1:0] cx_q [MAX_CORNERS];
	logic signed [COORD_W-1:0] cy_q [MAX_CORNERS];

	// Shared multiplier
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	// Trig
	logic [THETA_W-1:0]      theta_sel;
	logic [THETA_W:0]        phase;
	logic [THETA_W-1:0]      half, k;
	logic [18:0]             x2_q;
	logic [15:0]             t_val;
	logic [16:0]             u_val;
	logic [17:0]             s_val, s_rnd;
	logic [TRIG_W-1:0]       q_val;
	logic signed [TRIG_W-1:0] trig_q [4];

	// Cramer terms and point
	logic signed [ACC_W-1:0]   nx_q, ny_q, den_q;
	logic signed [ACC_W-1:0]   num_src;
	logic [ACC_W-1:0]          num_mag, den_mag;
	logic                      div_start, div_busy;
	logic signed [COORD_W-1:0] div_quo;
	logic signed [COORD_W-1:0] px_q, py_q;

	// Merge
	logic signed [COORD_W-1:0] cx_sel, cy_sel;
	logic signed [COORD_W:0]   dx, dy;
	logic [COORD_W:0]          adx, ady;
	logic [COORD_W+1:0]        man_dist;
	logic signed [18:0]        sum_x, sum_y;
	logic [17:0]               mag_x, mag_y;
	logic [COORD_W-1:0]        avg_q;

	// Output register
	logic                      out_valid_q, out_found_q, out_ovf_q, out_last_q;
	logic [COORD_W-1:0]        out_x_q, out_y_q;

	function automatic logic is_cls_y(input logic [THETA_W-1:0] t, input logic [THETA_W-1:0] t0);
		logic [THETA_W:0] d;
		d = {1'b0, t} - {1'b0, t0};
		if (d[THETA_W]) begin
			d = -d;
		end
		return (d > (THETA_W+1)'(384)) && (d < (THETA_W+1)'(640));
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_dist_q <= MERGE_DIST_RST;
			width_q      <= IMAGE_WIDTH_RST;
			height_q     <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MERGE_DIST:   merge_dist_q <= cfg_data;
				REG_IMAGE_WIDTH:  width_q      <= cfg_data;
				REG_IMAGE_HEIGHT: height_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Line memory: one write, one registered read
	assign line_full = (line_cnt_q == LCNT_W'(MAX_LINES));
	assign rd_idx    = (cmd.op == OP_READ_J) ? j_q[LIDX_W-1:0] : i_q[LIDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && !line_full) begin
			line_mem[line_cnt_q[LIDX_W-1:0]] <= {in_rho, in_theta};
		end
	end

	always_ff @(posedge clk) begin
		line_rd_q <= line_mem[rd_idx];
	end

	// Pair indexes and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			cidx_q <= '0;
		end else begin
			case (cmd.op)
				OP_START:      i_q    <= '0;
				OP_LATCH_I:    j_q    <= LCNT_W'(1);
				OP_NEXT_J:     j_q    <= j_q + 1'b1;
				OP_NEXT_I:     i_q    <= i_q + 1'b1;
				OP_SCAN_START: cidx_q <= '0;
				OP_EMIT_START: cidx_q <= '0;
				OP_SCAN_NEXT:  cidx_q <= cidx_q + 1'b1;
				OP_EMIT:       cidx_q <= cidx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Latch the two lines of a pair
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && line_cnt_q == '0) begin
			theta0_q <= in_theta;
		end
		if (cmd.op == OP_LATCH_I) begin
			rho_i_q   <= line_rd_q[LINE_W-1:THETA_W];
			theta_i_q <= line_rd_q[THETA_W-1:0];
		end
		if (cmd.op == OP_LATCH_J) begin
			rho_j_q   <= line_rd_q[LINE_W-1:THETA_W];
			theta_j_q <= line_rd_q[THETA_W-1:0];
		end
	end

	// Sine/cosine by polynomial over the quarter wave
	assign theta_sel = cmd.sub[1] ? theta_j_q : theta_i_q;
	assign phase     = {1'b0, theta_sel} + (cmd.sub[0] ? (THETA_W+1)'(0) : (THETA_W+1)'(512));
	assign half      = phase[THETA_W-1:0];
	assign k         = (half <= THETA_W'(512)) ? half
		: THETA_W'((THETA_W+1)'(1024) - {1'b0, half});
	assign t_val     = 16'd42047 - prod_q[33:18];
	assign u_val     = 17'd102944 - prod_q[34:18];
	assign s_val     = prod_q[26:9];
	assign s_rnd     = (s_val + 18'd1) >> 1;
	assign q_val     = (s_rnd > 18'd32767) ? 16'd32767 : s_rnd[TRIG_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.op == OP_TRIG) begin
			if (cmd.step == 3'd1) begin
				x2_q <= prod_q[18:0];
			end
			if (cmd.step == 3'd4) begin
				trig_q[cmd.sub] <= phase[THETA_W] ? -q_val : q_val;
			end
		end
	end

	// Merge arithmetic
	assign cidx_i   = cidx_q[CIDX_W-1:0];
	assign cx_sel   = cx_q[cidx_i];
	assign cy_sel   = cy_q[cidx_i];
	assign dx       = {cx_sel[COORD_W-1], cx_sel} - {px_q[COORD_W-1], px_q};
	assign dy       = {cy_sel[COORD_W-1], cy_sel} - {py_q[COORD_W-1], py_q};
	assign adx      = dx[COORD_W] ? -dx : dx;
	assign ady      = dy[COORD_W] ? -dy : dy;
	assign man_dist = {1'b0, adx} + {1'b0, ady};
	assign sum_x    = 19'(px_q) + (19'(cx_sel) <<< 3) + 19'(cx_sel);
	assign sum_y    = 19'(py_q) + (19'(cy_sel) <<< 3) + 19'(cy_sel);
	assign mag_x    = sum_x[18] ? 18'(-sum_x) : 18'(sum_x);
	assign mag_y    = sum_y[18] ? 18'(-sum_y) : 18'(sum_y);
	assign avg_q    = prod_q[33:19];

	// Multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_TRIG: begin
				case (cmd.step)
					3'd0: begin mul_a = MUL_W'(k);           mul_b = MUL_W'(k); end
					3'd1: begin mul_a = MUL_W'(prod_q[18:0]); mul_b = 20'sd4640; end
					3'd2: begin mul_a = MUL_W'(x2_q);        mul_b = MUL_W'(t_val); end
					3'd3: begin mul_a = MUL_W'(k);           mul_b = MUL_W'(u_val); end
					default: ;
				endcase
			end
			OP_PROD: begin
				case (cmd.step)
					3'd0: begin mul_a = MUL_W'(trig_q[3]); mul_b = MUL_W'(rho_i_q); end
					3'd1: begin mul_a = MUL_W'(trig_q[1]); mul_b = MUL_W'(rho_j_q); end
					3'd2: begin mul_a = MUL_W'(trig_q[0]); mul_b = MUL_W'(rho_j_q); end
					3'd3: begin mul_a = MUL_W'(trig_q[2]); mul_b = MUL_W'(rho_i_q); end
					3'd4: begin mul_a = MUL_W'(trig_q[0]); mul_b = MUL_W'(trig_q[3]); end
					3'd5: begin mul_a = MUL_W'(trig_q[1]); mul_b = MUL_W'(trig_q[2]); end
					default: ;
				endcase
			end
			OP_AVG: begin
				mul_b = 20'sd52429;
				if (cmd.step == 3'd0) begin
					mul_a = MUL_W'(mag_x);
				end else begin
					mul_a = MUL_W'(mag_y);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Accumulate Cramer terms
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PROD) begin
			case (cmd.step)
				3'd1: nx_q  <= prod_q[ACC_W-1:0];
				3'd2: nx_q  <= nx_q - prod_q[ACC_W-1:0];
				3'd3: ny_q  <= prod_q[ACC_W-1:0];
				3'd4: ny_q  <= ny_q - prod_q[ACC_W-1:0];
				3'd5: den_q <= prod_q[ACC_W-1:0];
				3'd6: den_q <= den_q - prod_q[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	// Divide numerator magnitude by denominator magnitude
	assign div_start = (cmd.op == OP_DIVX_GO) || (cmd.op == OP_DIVY_GO);
	assign num_src   = (cmd.op == OP_DIVY_GO) ? ny_q : nx_q;
	assign num_mag   = num_src[ACC_W-1] ? ACC_W'(-num_src) : ACC_W'(num_src);
	assign den_mag   = den_q[ACC_W-1] ? ACC_W'(-den_q) : ACC_W'(den_q);

	hlcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({num_mag, FRAC_SHIFT'(0)}),
		.den    (den_mag),
		.neg    (num_src[ACC_W-1] ^ den_q[ACC_W-1]),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIVX_TAKE) begin
			px_q <= div_quo;
		end
		if (cmd.op == OP_DIVY_TAKE) begin
			py_q <= div_quo;
		end
	end

	// Corner list update
	assign corner_full = (ccnt_q == CCNT_W'(MAX_CORNERS));

	always_ff @(posedge clk) begin
		if (cmd.op == OP_AVG && cmd.step == 3'd1) begin
			cx_q[cidx_i] <= sum_x[18] ? -avg_q : avg_q;
		end
		if (cmd.op == OP_AVG && cmd.step == 3'd2) begin
			cy_q[cidx_i] <= sum_y[18] ? -avg_q : avg_q;
		end
		if (cmd.op == OP_APPEND && !corner_full) begin
			cx_q[ccnt_q[CIDX_W-1:0]] <= px_q;
			cy_q[ccnt_q[CIDX_W-1:0]] <= py_q;
		end
	end

	// Counts and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt_q <= '0;
			ccnt_q     <= '0;
			dropped_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (line_full) begin
						dropped_q <= 1'b1;
					end else begin
						line_cnt_q <= line_cnt_q + 1'b1;
					end
				end
				OP_START: ccnt_q <= '0;
				OP_APPEND: begin
					if (corner_full) begin
						dropped_q <= 1'b1;
					end else begin
						ccnt_q <= ccnt_q + 1'b1;
					end
				end
				OP_EMIT: begin
					if (stat.emit_last) begin
						line_cnt_q <= '0;
						ccnt_q     <= '0;
						dropped_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: load a beat, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_found_q <= (ccnt_q != '0);
			out_x_q     <= (ccnt_q != '0) ? cx_sel : '0;
			out_y_q     <= (ccnt_q != '0) ? cy_sel : '0;
			out_ovf_q   <= dropped_q;
			out_last_q  <= stat.emit_last;
		end
	end

	// Status to the controller
	always_comb begin
		stat.cls_y     = is_cls_y(line_rd_q[THETA_W-1:0], theta0_q);
		stat.i_end     = (i_q == line_cnt_q);
		stat.j_end     = (j_q == line_cnt_q);
		stat.den_zero  = (den_q == '0);
		stat.div_busy  = div_busy;
		stat.in_bounds = ($signed({px_q[COORD_W-1], px_q}) < $signed({3'b000, width_q}))
			&& ($signed({py_q[COORD_W-1], py_q}) < $signed({3'b000, height_q}));
		stat.scan_end  = (cidx_q == ccnt_q);
		stat.hit       = (man_dist < (COORD_W+2)'(merge_dist_q));
		stat.out_free  = !out_valid_q || m_tready;
		stat.emit_last = (ccnt_q == '0) || (cidx_q == ccnt_q - 1'b1);
	end

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_ovf   = out_ovf_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

@@ src/hlcf_ctrl.sv @@
// Controller state machine: load, pair walk, intersect, merge and emit sequencing.
`default_nettype none
module hlcf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tlast,
	output logic                   s_tready,
	input  wire hlcf_pkg::stat_t   stat,
	output hlcf_pkg::cmd_t         cmd
);
	import hlcf_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] step_q, step_d;
	logic [1:0] sub_q, sub_d;

	// State and step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
			sub_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sub_q   <= sub_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		sub_d    = sub_q;
		s_tready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		cmd.sub  = sub_q;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					if (s_tlast) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				cmd.op  = OP_START;
				state_d = ST_RD_I;
			end
			ST_RD_I: begin
				if (stat.i_end) begin
					cmd.op  = OP_EMIT_START;
					state_d = ST_EMIT;
				end else begin
					cmd.op  = OP_READ_I;
					state_d = ST_LAT_I;
				end
			end
			ST_LAT_I: begin
				cmd.op  = OP_LATCH_I;
				state_d = stat.cls_y ? ST_NEXT_I : ST_RD_J;
			end
			ST_RD_J: begin
				if (stat.j_end) begin
					state_d = ST_NEXT_I;
				end else begin
					cmd.op  = OP_READ_J;
					state_d = ST_LAT_J;
				end
			end
			ST_LAT_J: begin
				cmd.op = OP_LATCH_J;
				if (stat.cls_y) begin
					step_d  = '0;
					sub_d   = '0;
					state_d = ST_TRIG;
				end else begin
					state_d = ST_NEXT_J;
				end
			end
			ST_TRIG: begin
				cmd.op = OP_TRIG;
				if (step_q == 3'd4) begin
					step_d = '0;
					if (sub_q == 2'd3) begin
						state_d = ST_PROD;
					end else begin
						sub_d = sub_q + 1'b1;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_PROD: begin
				cmd.op = OP_PROD;
				if (step_q == 3'd6) begin
					step_d  = '0;
					state_d = ST_DIVX_GO;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DIVX_GO: begin
				if (stat.den_zero) begin
					state_d = ST_NEXT_J;
				end else begin
					cmd.op  = OP_DIVX_GO;
					state_d = ST_DIVX_WAIT;
				end
			end
			ST_DIVX_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_DIVX_TAKE;
					state_d = ST_DIVY_GO;
				end
			end
			ST_DIVY_GO: begin
				cmd.op  = OP_DIVY_GO;
				state_d = ST_DIVY_WAIT;
			end
			ST_DIVY_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_DIVY_TAKE;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.in_bounds) begin
					cmd.op  = OP_SCAN_START;
					state_d = ST_SCAN;
				end else begin
					state_d = ST_NEXT_J;
				end
			end
			ST_SCAN: begin
				if (stat.scan_end) begin
					state_d = ST_APPEND;
				end else if (stat.hit) begin
					step_d  = '0;
					state_d = ST_AVG;
				end else begin
					cmd.op = OP_SCAN_NEXT;
				end
			end
			ST_AVG: begin
				cmd.op = OP_AVG;
				if (step_q == 3'd2) begin
					step_d  = '0;
					state_d = ST_NEXT_J;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_APPEND: begin
				cmd.op  = OP_APPEND;
				state_d = ST_NEXT_J;
			end
			ST_NEXT_J: begin
				cmd.op  = OP_NEXT_J;
				state_d = ST_RD_J;
			end
			ST_NEXT_I: begin
				cmd.op  = OP_NEXT_I;
				state_d = ST_RD_I;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.op = OP_EMIT;
					if (stat.emit_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule
`default_nettype wire

@@ src/hough_line_corner_finder.sv @@
// Top level of the Hough line corner finder.
// Lines load at one beat per cycle; the last line of a set starts the compute phase.
// Each X/Y line pair runs four trig evaluations and the Cramer products on one shared multiplier,
// then two divides and a scan of the stored corners.
// Corners leave via the output register, one beat per cycle while m_tready is high; input waits.
// Reset clears counters, flags and state and loads the register defaults; stores are not cleared.
`default_nettype none
module hough_line_corner_finder #(
	parameter int MAX_LINES   = 32,
	parameter int MAX_CORNERS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [hlcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hlcf_pkg::REG_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [31:0]                    s_tdata,  // line_rho[15:0], line_theta[25:16]
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [31:0]                         m_tdata,  // corner_x[14:0], corner_y[29:15]
	output logic [1:0]                          m_tuser,  // found[0], overflow[1]
	output logic                                m_tlast
);
	import hlcf_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic               found, ovf;
	logic [COORD_W-1:0] cx, cy;

	hlcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hlcf_dp #(
		.MAX_LINES   (MAX_LINES),
		.MAX_CORNERS (MAX_CORNERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_rho    (s_tdata[RHO_W-1:0]),
		.in_theta  (s_tdata[LINE_W-1:RHO_W]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_found (found),
		.out_x     (cx),
		.out_y     (cy),
		.out_ovf   (ovf),
		.out_last  (m_tlast)
	);

	// Pack the result beat
	assign m_tdata = {2'b00, cy, cx};
	assign m_tuser = {ovf, found};

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the Hough line corner finder: line sets in, corners out.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hlcf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int LINE_CAP   = 32;
	localparam int CORNER_CAP = 16;
	localparam int IDLE_LIMIT = 200000;

	typedef struct {
		bit          found;
		logic [14:0] x;
		logic [14:0] y;
		bit          ovf;
		bit          last;
	} corner_t;

	// Corner predictor and store of expected corner beats
	class corner_board;
		int unsigned merge_dist = MERGE_DIST_RST;
		int unsigned img_w = IMAGE_WIDTH_RST;
		int unsigned img_h = IMAGE_HEIGHT_RST;
		logic [15:0] rho_q[$];
		logic [9:0]  theta_q[$];
		bit          lost;
		int          cx[$];
		int          cy[$];
		corner_t     want[$];
		int          mismatches;
		int          seen;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
			case (idx)
				REG_MERGE_DIST:   merge_dist = val;
				REG_IMAGE_WIDTH:  img_w = val;
				REG_IMAGE_HEIGHT: img_h = val;
				default: ;
			endcase
		endfunction

		function longint quarter(longint unsigned k);
			longint unsigned x2, t, u, s, q;
			x2 = k * k;
			t = 42047 - ((x2 * 4640) >> 18);
			u = 102944 - ((x2 * t) >> 18);
			s = (k * u) >> 9;
			q = (s + 1) >> 1;
			if (q > 32767) q = 32767;
			return longint'(q);
		endfunction

		function longint sine(int unsigned p);
			int unsigned half, k;
			longint v;
			half = p & 1023;
			k = (half <= 512) ? half : 1024 - half;
			v = quarter(k);
			return (p & 1024) ? -v : v;
		endfunction

		function bit is_y(int i);
			int d;
			d = int'(theta_q[i]) - int'(theta_q[0]);
			if (d < 0) d = -d;
			return d > 384 && d < 640;
		endfunction

		function int sat(longint v);
			if (v < -16384) return -16384;
			if (v > 16383) return 16383;
			return int'(v);
		endfunction

		function void merge(int x, int y);
			int d;
			for (int j = 0; j < cx.size(); j++) begin
				d = (cx[j] > x ? cx[j] - x : x - cx[j]) + (cy[j] > y ? cy[j] - y : y - cy[j]);
				if (d < int'(merge_dist)) begin
					cx[j] = (x + 9 * cx[j]) / 10;
					cy[j] = (y + 9 * cy[j]) / 10;
					return;
				end
			end
			if (cx.size() < CORNER_CAP) begin
				cx = {cx, x};
				cy = {cy, y};
			end else
				lost = 1;
		endfunction

		function void intersect_pair(int i, int j);
			longint a, b, c, d, e, f, den, nx, ny;
			int x, y;
			a = sine(theta_q[i] + 512);
			b = sine(theta_q[i]);
			c = longint'($signed(rho_q[i]));
			d = sine(theta_q[j] + 512);
			e = sine(theta_q[j]);
			f = longint'($signed(rho_q[j]));
			den = a * e - b * d;
			nx = e * c - b * f;
			ny = a * f - d * c;
			if (den == 0) return;
			x = sat((nx * 2048) / den);
			y = sat((ny * 2048) / den);
			if (x < int'(img_w) && y < int'(img_h)) merge(x, y);
		endfunction

		// Store the line; on the last one, solve the set and queue its corners
		function void note_line(logic [15:0] rho, logic [9:0] theta, bit last);
			corner_t r;
			if (rho_q.size() < LINE_CAP) begin
				rho_q = {rho_q, rho};
				theta_q = {theta_q, theta};
			end else
				lost = 1;
			if (!last) return;
			cx.delete();
			cy.delete();
			for (int i = 0; i < rho_q.size(); i++) begin
				if (is_y(i)) continue;
				for (int j = 1; j < rho_q.size(); j++)
					if (is_y(j)) intersect_pair(i, j);
			end
			if (cx.size() == 0) begin
				r = '{0, 15'd0, 15'd0, lost, 1};
				want = {want, r};
			end else
				for (int i = 0; i < cx.size(); i++) begin
					r = '{1, cx[i][14:0], cy[i][14:0], lost, i == cx.size() - 1};
					want = {want, r};
				end
			rho_q.delete();
			theta_q.delete();
			lost = 0;
		endfunction

		function void check(corner_t got);
			corner_t w;
			seen++;
			if (want.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected corner beat: found=%0b x=%0d y=%0d", got.found,
						$signed(got.x), $signed(got.y));
				return;
			end
			w = want.pop_front();
			if (got.found !== w.found || got.x !== w.x || got.y !== w.y ||
					got.ovf !== w.ovf || got.last !== w.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("corner mismatch: exp f=%0b x=%0d y=%0d o=%0b l=%0b",
						w.found, $signed(w.x), $signed(w.y), w.ovf, w.last);
					$display("                 got f=%0b x=%0d y=%0d o=%0b l=%0b",
						got.found, $signed(got.x), $signed(got.y), got.ovf, got.last);
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic s_tvalid, s_tready, s_tlast;
	logic [31:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [31:0] m_tdata;
	logic [1:0] m_tuser;

	corner_board board = new();
	bit calm;
	int lines_sent, sets_sent, idle_cycles, out_stall;

	hough_line_corner_finder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Accept corner beats with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall <= 0;
		end else if (m_tvalid && m_tready) begin
			board.check('{m_tuser[0], m_tdata[14:0], m_tdata[29:15], m_tuser[1], m_tlast});
			out_stall <= calm ? 0 : $urandom_range(0, 17);
			if (!calm && out_stall != 0) m_tready <= 1'b0;
		end else if (!m_tready) begin
			if (out_stall == 0) m_tready <= 1'b1;
			else out_stall <= out_stall - 1;
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d corner beats pending", board.want.size());
			$display("** hough_line_corner_finder: FAILED **");
			$finish;
		end
	end

	task automatic send_line(logic [15:0] rho, logic [9:0] theta, bit last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, theta, rho};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.note_line(rho, theta, last);
		lines_sent++;
		if (last) sets_sent++;
	endtask

	// Drain the block, then write all registers on consecutive cycles
	task automatic write_regs(int md, int w, int h);
		s_tvalid <= 1'b0;
		while (board.want.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MERGE_DIST;
		cfg_data <= REG_W'(md);
		@(posedge clk);
		board.set_reg(REG_MERGE_DIST, REG_W'(md));
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= REG_W'(w);
		@(posedge clk);
		board.set_reg(REG_IMAGE_WIDTH, REG_W'(w));
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= REG_W'(h);
		@(posedge clk);
		board.set_reg(REG_IMAGE_HEIGHT, REG_W'(h));
		cfg_index <= REG_SPARE;
		cfg_data <= REG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// A grid of near-perpendicular lines with random content
	task automatic send_grid(int n);
		int t0;
		logic [15:0] rho;
		logic [9:0] theta;
		t0 = $urandom_range(0, 1023);
		for (int i = 0; i < n; i++) begin
			if (i == 0 || $urandom_range(0, 1))
				theta = 10'((t0 + $urandom_range(0, 30) + 1009) % 1024);
			else
				theta = 10'((t0 + 492 + $urandom_range(0, 40)) % 1024);
			if (i == 0) theta = 10'(t0);
			rho = 16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 7000));
			send_line(rho, theta, i == n - 1);
		end
	endtask

	task automatic send_noise(int n);
		for (int i = 0; i < n; i++) send_line(16'($urandom), 10'($urandom), i == n - 1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		calm = 1'b1;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rectangle at reset settings
		send_line(16'd1600, 10'd0, 0);
		send_line(16'd4800, 10'd0, 0);
		send_line(16'd800, 10'd512, 0);
		send_line(16'd3200, 10'd512, 1);
		// Lone line: nothing found
		send_line(16'h8000, 10'd1023, 1);
		// Near-duplicate lines merge; negative and extreme rho
		send_line(16'd1600, 10'd0, 0);
		send_line(16'd1620, 10'd2, 0);
		send_line(16'hFF00, 10'd511, 0);
		send_line(16'h7FFF, 10'd600, 1);
		calm = 1'b0;
		// Corner store overflows: 5 x 5 distinct corners
		for (int i = 0; i < 10; i++)
			send_line(16'(640 + 640 * (i % 5)), i < 5 ? 10'd0 : 10'd512, i == 9);
		// Line store overflows, final two lines dropped
		for (int i = 0; i < 34; i++) send_line(16'(320 * i), i % 2 ? 10'd512 : 10'd0, i == 33);

		write_regs(1, 1, 1);
		send_grid(4);
		write_regs(8191, 4096, 4096);
		send_grid(5);
		send_line(16'h8000, 10'd1023, 0);
		send_line(16'h7FFF, 10'd0, 1);

		// Random sets, settings changed every few sets
		while (lines_sent < 310) begin
			if (sets_sent % 8 == 0) begin
				case ($urandom_range(0, 3))
					0: write_regs(10, 640, 480);
					1: write_regs($urandom_range(1, 8191), $urandom_range(1, 4096),
						$urandom_range(1, 4096));
					2: write_regs($urandom_range(1, 60), 4096, 4096);
					default: write_regs($urandom_range(1, 30), $urandom_range(200, 800),
						$urandom_range(200, 800));
				endcase
			end
			calm = $urandom_range(0, 3) == 0;
			case ($urandom_range(0, 19))
				0:          send_grid($urandom_range(33, 35));
				1, 2, 3, 4: send_noise($urandom_range(1, 6));
				default:    send_grid($urandom_range(2, 8));
			endcase
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		while (board.want.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d line sets, %0d lines, %0d corner beats checked",
			sets_sent, lines_sent, board.seen);
		$display("register settings swept incl. extremes; %0d mismatches", board.mismatches);
		if (board.mismatches == 0 && board.want.size() == 0)
			$display("** hough_line_corner_finder: PASSED **");
		else
			$display("** hough_line_corner_finder: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
src/hlcf_pkg.sv
src/hlcf_div.sv
src/hlcf_dp.sv
src/hlcf_ctrl.sv
src/hough_line_corner_finder.sv
tb/sv/tb_top.sv
